### src/spi_ee_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the SPI serial EEPROM device model.
package spi_ee_pkg;

  // Item codes on the opcode input
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Command bytes on the wire
  localparam logic [7:0] BYTE_WRSR  = 8'h01;
  localparam logic [7:0] BYTE_WRITE = 8'h02;
  localparam logic [7:0] BYTE_READ  = 8'h03;
  localparam logic [7:0] BYTE_WRDI  = 8'h04;
  localparam logic [7:0] BYTE_RDSR  = 8'h05;
  localparam logic [7:0] BYTE_WREN  = 8'h06;

  localparam logic [7:0]  MISO_IDLE   = 8'hFF;
  localparam logic [7:0]  ERASED_BYTE = 8'hFF;
  localparam logic [15:0] TICKS_RESET = 16'd6000;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_RELEASE,
    KIND_TICK,
    KIND_IDLE
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  data;
  } item_t;

  typedef enum logic [2:0] {
    PH_CMD,
    PH_AHI,
    PH_ALO,
    PH_DATA,
    PH_STAT,
    PH_WRSR,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_WRSR  = 3'd1,
    CMD_WRITE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_WRDI  = 3'd4,
    CMD_RDSR  = 3'd5,
    CMD_WREN  = 3'd6
  } cmd_t;

  typedef struct packed {
    logic [7:0] miso;
    logic       wip;
    logic       wen;
  } result_t;

endpackage

### src/spi_ee_front.sv
`timescale 1ns / 1ps
// Front end: takes input transactions, classifies them and queues them for the back end.
module spi_ee_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [1:0]           opcode,
  input  logic [7:0]           mosi_byte,
  input  logic                 hold,
  input  logic                 q_pop,
  output logic                 full,
  output logic                 q_valid,
  output spi_ee_pkg::item_t    q_item
);

  spi_ee_pkg::item_t      slot [2];
  spi_ee_pkg::item_kind_t kind;
  logic                   rd_ptr;
  logic                   wr_ptr;
  logic [1:0]             count;
  logic                   push_ok;
  logic                   pop_ok;

  always_comb begin
    unique case (opcode)
      spi_ee_pkg::OP_BYTE:    kind = spi_ee_pkg::KIND_BYTE;
      spi_ee_pkg::OP_RELEASE: kind = spi_ee_pkg::KIND_RELEASE;
      spi_ee_pkg::OP_TICK:    kind = spi_ee_pkg::KIND_TICK;
      default:                kind = spi_ee_pkg::KIND_IDLE;
    endcase
  end

  // Refuse items when both slots are taken or while the back end sweeps the array after reset
  assign full    = (count == 2'd2) | hold;
  assign push_ok = push & ~full;
  assign q_valid = (count != 2'd0);
  assign pop_ok  = q_pop & q_valid;
  assign q_item  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_ok) wr_ptr <= ~wr_ptr;
      if (pop_ok)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push_ok} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      slot[wr_ptr].kind <= kind;
      slot[wr_ptr].data <= mosi_byte;
    end
  end

endmodule

### src/spi_ee_back.sv
`timescale 1ns / 1ps
// Back end: command sequencer, memory array, result stage and result queue.
module spi_ee_back #(
  parameter int MEM_BYTES  = 32768,
  parameter int PAGE_BYTES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  input  logic                 q_valid,
  input  spi_ee_pkg::item_t    q_item,
  output logic                 q_pop,
  output logic                 clearing,
  input  logic                 pop,
  output logic                 empty,
  output spi_ee_pkg::result_t  head
);

  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int PAGE_W    = $clog2(PAGE_BYTES);
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int CNT_W     = OUT_PTR_W + 1;

  localparam logic [ADDR_W-1:0] MEM_LAST      = ADDR_W'(MEM_BYTES - 1);
  localparam logic [ADDR_W:0]   MEM_WIDE      = (ADDR_W + 1)'(MEM_BYTES);
  localparam logic [ADDR_W-1:0] LIMIT_QUARTER = ADDR_W'(MEM_BYTES - MEM_BYTES / 4);
  localparam logic [ADDR_W-1:0] LIMIT_HALF    = ADDR_W'(MEM_BYTES / 2);
  localparam logic [PAGE_W-1:0] PAGE_LAST     = PAGE_W'(PAGE_BYTES - 1);
  localparam logic [PAGE_W:0]   PAGE_WIDE     = (PAGE_W + 1)'(PAGE_BYTES);
  localparam logic [PAGE_W:0]   MEM_REM       = (PAGE_W + 1)'(MEM_BYTES % PAGE_BYTES);

  typedef logic [ADDR_W-1:0] hi_tab_t  [256];
  typedef logic [PAGE_W-1:0] off_tab_t [256];

  // High address byte times 256, reduced into the array
  function automatic hi_tab_t build_hi_addr();
    hi_tab_t tab;
    for (int i = 0; i < 256; i++) tab[i] = ADDR_W'((i * 256) % MEM_BYTES);
    return tab;
  endfunction

  // Page offset contributed by the reduced high byte
  function automatic off_tab_t build_hi_off();
    off_tab_t tab;
    for (int i = 0; i < 256; i++) tab[i] = PAGE_W'(((i * 256) % MEM_BYTES) % PAGE_BYTES);
    return tab;
  endfunction

  function automatic off_tab_t build_lo_off();
    off_tab_t tab;
    for (int i = 0; i < 256; i++) tab[i] = PAGE_W'(i % PAGE_BYTES);
    return tab;
  endfunction

  localparam hi_tab_t  HI_ADDR = build_hi_addr();
  localparam off_tab_t HI_OFF  = build_hi_off();
  localparam off_tab_t LO_OFF  = build_lo_off();

  // Sequencer state
  spi_ee_pkg::phase_t phase, phase_next;
  spi_ee_pkg::cmd_t   cmd, cmd_next;
  logic [7:0]         addr_hi, addr_hi_next;
  logic [ADDR_W-1:0]  addr, addr_next;
  logic [PAGE_W-1:0]  off, off_next;
  logic               latch, latch_next;
  logic [1:0]         prot, prot_next;
  logic [15:0]        busy, busy_next;
  logic               seen, seen_next;
  logic [15:0]        ticks;
  logic [ADDR_W-1:0]  clear_addr;

  // Execute-stage signals
  logic               adv;
  logic               space_ok;
  logic               busy_on;
  logic               protected_hit;
  logic               use_mem;
  logic [7:0]         miso_val;
  logic [7:0]         status;
  logic               wr_data;

  // Address load arithmetic
  logic [ADDR_W:0]    addr_sum;
  logic               addr_wrap;
  logic [ADDR_W-1:0]  addr_mod;
  logic [PAGE_W:0]    off_sum;
  logic [PAGE_W:0]    off_red;
  logic [PAGE_W-1:0]  off_mod;
  logic               addr_is_last;
  logic               off_is_last;

  // Memory
  logic [7:0]         mem [MEM_BYTES];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [7:0]         mem_wd;
  logic [7:0]         rdata;

  // Result stage and queue
  logic                  s2_valid;
  logic                  s2_use_mem;
  spi_ee_pkg::result_t   s2_res;
  spi_ee_pkg::result_t   res2;
  spi_ee_pkg::result_t   oq [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]  oq_rd;
  logic [OUT_PTR_W-1:0]  oq_wr;
  logic [CNT_W-1:0]      out_count;
  logic                  pop_ok;

  assign busy_on  = (busy != 16'd0);
  assign status   = {4'b0000, prot, latch, busy_on};
  assign space_ok = s2_valid ? (out_count < CNT_W'(OUT_DEPTH - 1))
                             : (out_count < CNT_W'(OUT_DEPTH));
  assign adv      = q_valid & ~clearing & space_ok;
  assign q_pop    = adv;

  always_comb begin
    unique case (prot)
      2'd0:    protected_hit = 1'b0;
      2'd1:    protected_hit = (addr >= LIMIT_QUARTER);
      2'd2:    protected_hit = (addr >= LIMIT_HALF);
      default: protected_hit = 1'b1;
    endcase
  end

  // Address and page offset from the two address bytes
  always_comb begin
    addr_sum  = {1'b0, HI_ADDR[addr_hi]} + (ADDR_W + 1)'(q_item.data);
    addr_wrap = (addr_sum >= MEM_WIDE);
    addr_mod  = addr_wrap ? ADDR_W'(addr_sum - MEM_WIDE) : ADDR_W'(addr_sum);
    off_sum   = {1'b0, HI_OFF[addr_hi]} + {1'b0, LO_OFF[q_item.data]};
    off_red   = (off_sum >= PAGE_WIDE) ? (off_sum - PAGE_WIDE) : off_sum;
    if (!addr_wrap) begin
      off_mod = PAGE_W'(off_red);
    end else if (off_red >= MEM_REM) begin
      off_mod = PAGE_W'(off_red - MEM_REM);
    end else begin
      off_mod = PAGE_W'(off_red + PAGE_WIDE - MEM_REM);
    end
  end

  assign addr_is_last = (addr == MEM_LAST);
  assign off_is_last  = (off == PAGE_LAST);

  // Next phase
  always_comb begin
    phase_next = phase;
    if (adv) begin
      unique case (q_item.kind)
        spi_ee_pkg::KIND_BYTE: begin
          unique case (phase)
            spi_ee_pkg::PH_CMD: begin
              if (busy_on && q_item.data != spi_ee_pkg::BYTE_RDSR) begin
                phase_next = spi_ee_pkg::PH_SKIP;
              end else begin
                unique case (q_item.data)
                  spi_ee_pkg::BYTE_RDSR:  phase_next = spi_ee_pkg::PH_STAT;
                  spi_ee_pkg::BYTE_READ:  phase_next = spi_ee_pkg::PH_AHI;
                  spi_ee_pkg::BYTE_WRITE:
                    phase_next = latch ? spi_ee_pkg::PH_AHI : spi_ee_pkg::PH_SKIP;
                  spi_ee_pkg::BYTE_WRSR:
                    phase_next = latch ? spi_ee_pkg::PH_WRSR : spi_ee_pkg::PH_SKIP;
                  default:                phase_next = spi_ee_pkg::PH_SKIP;
                endcase
              end
            end
            spi_ee_pkg::PH_AHI:  phase_next = spi_ee_pkg::PH_ALO;
            spi_ee_pkg::PH_ALO:  phase_next = spi_ee_pkg::PH_DATA;
            spi_ee_pkg::PH_WRSR: phase_next = spi_ee_pkg::PH_SKIP;
            spi_ee_pkg::PH_DATA,
            spi_ee_pkg::PH_STAT,
            spi_ee_pkg::PH_SKIP: phase_next = phase;
            default:             phase_next = spi_ee_pkg::PH_CMD;
          endcase
        end
        spi_ee_pkg::KIND_RELEASE: phase_next = spi_ee_pkg::PH_CMD;
        default:                  phase_next = phase;
      endcase
    end
  end

  // Datapath and outputs of the execute step
  always_comb begin
    cmd_next     = cmd;
    addr_hi_next = addr_hi;
    addr_next    = addr;
    off_next     = off;
    latch_next   = latch;
    prot_next    = prot;
    busy_next    = busy;
    seen_next    = seen;
    use_mem      = 1'b0;
    wr_data      = 1'b0;
    miso_val     = spi_ee_pkg::MISO_IDLE;
    if (adv) begin
      unique case (q_item.kind)
        spi_ee_pkg::KIND_BYTE: begin
          unique case (phase)
            spi_ee_pkg::PH_CMD: begin
              if (!busy_on || q_item.data == spi_ee_pkg::BYTE_RDSR) begin
                unique case (q_item.data)
                  spi_ee_pkg::BYTE_WREN: begin
                    cmd_next   = spi_ee_pkg::CMD_WREN;
                    latch_next = 1'b1;
                  end
                  spi_ee_pkg::BYTE_WRDI: begin
                    cmd_next   = spi_ee_pkg::CMD_WRDI;
                    latch_next = 1'b0;
                  end
                  spi_ee_pkg::BYTE_RDSR: cmd_next = spi_ee_pkg::CMD_RDSR;
                  spi_ee_pkg::BYTE_READ: cmd_next = spi_ee_pkg::CMD_READ;
                  spi_ee_pkg::BYTE_WRITE:
                    cmd_next = latch ? spi_ee_pkg::CMD_WRITE : spi_ee_pkg::CMD_NONE;
                  spi_ee_pkg::BYTE_WRSR:
                    cmd_next = latch ? spi_ee_pkg::CMD_WRSR : spi_ee_pkg::CMD_NONE;
                  default: cmd_next = spi_ee_pkg::CMD_NONE;
                endcase
              end
            end
            spi_ee_pkg::PH_AHI: addr_hi_next = q_item.data;
            spi_ee_pkg::PH_ALO: begin
              addr_next = addr_mod;
              off_next  = off_mod;
            end
            spi_ee_pkg::PH_DATA: begin
              if (cmd == spi_ee_pkg::CMD_READ) begin
                use_mem = 1'b1;
                if (addr_is_last) begin
                  addr_next = '0;
                  off_next  = '0;
                end else begin
                  addr_next = addr + 1'b1;
                  off_next  = off_is_last ? '0 : off + 1'b1;
                end
              end else begin
                wr_data   = ~protected_hit;
                seen_next = 1'b1;
                // Wrap inside the page first, then at the end of the array
                if (off_is_last) begin
                  addr_next = addr - ADDR_W'(off);
                  off_next  = '0;
                end else if (addr_is_last) begin
                  addr_next = '0;
                  off_next  = '0;
                end else begin
                  addr_next = addr + 1'b1;
                  off_next  = off + 1'b1;
                end
              end
            end
            spi_ee_pkg::PH_STAT: miso_val = status;
            spi_ee_pkg::PH_WRSR: begin
              prot_next = q_item.data[3:2];
              seen_next = 1'b1;
            end
            default: ;
          endcase
        end
        spi_ee_pkg::KIND_RELEASE: begin
          if (seen && (cmd == spi_ee_pkg::CMD_WRITE || cmd == spi_ee_pkg::CMD_WRSR)) begin
            busy_next  = ticks;
            latch_next = 1'b0;
          end
          cmd_next  = spi_ee_pkg::CMD_NONE;
          seen_next = 1'b0;
        end
        spi_ee_pkg::KIND_TICK: begin
          if (busy_on) busy_next = busy - 16'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= spi_ee_pkg::PH_CMD;
      cmd     <= spi_ee_pkg::CMD_NONE;
      addr_hi <= 8'd0;
      addr    <= '0;
      off     <= '0;
      latch   <= 1'b0;
      prot    <= 2'd0;
      busy    <= 16'd0;
      seen    <= 1'b0;
    end else begin
      phase   <= phase_next;
      cmd     <= cmd_next;
      addr_hi <= addr_hi_next;
      addr    <= addr_next;
      off     <= off_next;
      latch   <= latch_next;
      prot    <= prot_next;
      busy    <= busy_next;
      seen    <= seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks <= spi_ee_pkg::TICKS_RESET;
    end else if (cfg_we) begin
      ticks <= cfg_data;
    end
  end

  // Erase sweep after reset, one byte per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == MEM_LAST) clearing <= 1'b0;
      else clear_addr <= clear_addr + 1'b1;
    end
  end

  assign mem_we = clearing | wr_data;
  assign mem_wa = clearing ? clear_addr : addr;
  assign mem_wd = clearing ? spi_ee_pkg::ERASED_BYTE : q_item.data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

  // Result stage: read data joins the item in the cycle after execute
  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= adv;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_use_mem  <= use_mem;
      s2_res.miso <= miso_val;
      s2_res.wip  <= (busy_next != 16'd0);
      s2_res.wen  <= latch_next;
    end
  end

  always_comb begin
    res2 = s2_res;
    if (s2_use_mem) res2.miso = rdata;
  end

  assign empty  = (out_count == '0);
  assign pop_ok = pop & ~empty;
  assign head   = oq[oq_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_rd     <= '0;
      oq_wr     <= '0;
      out_count <= '0;
    end else begin
      if (s2_valid) oq_wr <= oq_wr + 1'b1;
      if (pop_ok)   oq_rd <= oq_rd + 1'b1;
      out_count <= out_count + CNT_W'(s2_valid) - CNT_W'(pop_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) oq[oq_wr] <= res2;
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    (out_count <= CNT_W'(OUT_DEPTH)))
    else $error("result queue overflow");

  a_no_exec_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !adv)
    else $error("item executed during erase sweep");

  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && !pop_ok) |=> (out_count == CNT_W'($past(out_count) + 1'b1)))
    else $error("result stage output lost");

  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    (adv && q_item.kind == spi_ee_pkg::KIND_RELEASE && seen &&
     (cmd == spi_ee_pkg::CMD_WRITE || cmd == spi_ee_pkg::CMD_WRSR))
    |=> (busy == $past(ticks) && !latch))
    else $error("write cycle not started at release");

endmodule

### src/spi_eeprom_device_model_core.sv
`timescale 1ns / 1ps
// Top level of the SPI serial EEPROM device model.
//
//   channel  | handshake      | payload
//   ---------+----------------+-------------------------------------------
//   input    | push / full    | opcode, mosi_byte
//   result   | pop / empty    | miso_byte, write_in_progress, write_enabled
//   config   | write_cycle_ticks_we | write_cycle_ticks
//
// One item per cycle sustained while no erase sweep runs and the result side has
// room; each item is executed by the command sequencer, and a result reaches the
// ports through the input queue, the result stage with its registered array read,
// and the result queue. After reset the array is erased one byte per cycle, all
// MEM_BYTES bytes, with full held high; configuration writes are taken throughout.
// A stalled result side fills a four-entry result queue, then a two-entry input
// queue, before full rises.
module spi_eeprom_device_model_core #(
  parameter int MEM_BYTES  = 32768,
  parameter int PAGE_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [7:0]  mosi_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  miso_byte,
  output logic        write_in_progress,
  output logic        write_enabled,
  input  logic        write_cycle_ticks_we,
  input  logic [15:0] write_cycle_ticks
);

  spi_ee_pkg::item_t   q_item;
  spi_ee_pkg::result_t head;
  logic                q_valid;
  logic                q_pop;
  logic                clearing;

  spi_ee_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .opcode    (opcode),
    .mosi_byte (mosi_byte),
    .hold      (clearing),
    .q_pop     (q_pop),
    .full      (full),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  spi_ee_back #(
    .MEM_BYTES  (MEM_BYTES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (write_cycle_ticks_we),
    .cfg_data (write_cycle_ticks),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .clearing (clearing),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  assign miso_byte         = head.miso;
  assign write_in_progress = head.wip;
  assign write_enabled     = head.wen;

endmodule

### test/spi_eeprom_device_model_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the SPI serial EEPROM device model core.
module spi_eeprom_device_model_core_tb;
  import spi_ee_pkg::*;

  localparam int MEM_SZ      = 32768;
  localparam int PAGE_SZ     = 64;
  localparam int CYCLE_LIMIT = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  opcode = OP_BYTE;
  logic [7:0]  mosi_byte = 8'h00;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  miso_byte;
  logic        write_in_progress;
  logic        write_enabled;
  logic        ticks_we = 1'b0;
  logic [15:0] ticks_val = TICKS_RESET;

  spi_eeprom_device_model_core #(
    .MEM_BYTES (MEM_SZ),
    .PAGE_BYTES(PAGE_SZ)
  ) uut (
    .clk                 (clk),
    .rst                 (rst),
    .push                (push),
    .full                (full),
    .opcode              (opcode),
    .mosi_byte           (mosi_byte),
    .empty               (empty),
    .pop                 (pop),
    .miso_byte           (miso_byte),
    .write_in_progress   (write_in_progress),
    .write_enabled       (write_enabled),
    .write_cycle_ticks_we(ticks_we),
    .write_cycle_ticks   (ticks_val)
  );

  // Device image kept by the testbench
  logic [7:0]  ee_image [0:MEM_SZ-1];
  phase_t      ee_phase;
  cmd_t        ee_cmd;
  logic [14:0] ee_addr;
  logic        ee_wel;
  logic [1:0]  ee_bp;
  logic [15:0] ee_busy;
  logic        ee_seen;
  logic [15:0] cycle_len;

  item_t   pending [$];
  result_t due_results [$];
  result_t want;
  item_t   nxt;
  int      in_flight = 0;
  int      queued = 0;
  int      errors = 0;
  int      send_gap = 0;
  int      pop_gap = 0;
  int      cycles = 0;
  bit      calm = 1'b0;
  logic [15:0] last_write = 16'h0000;

  initial forever #2 clk = ~clk;

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  // Apply one transaction to the device image and queue the response it gives.
  task automatic advance_device(input item_kind_t kind, input logic [7:0] b);
    logic [7:0]  miso;
    logic [14:0] a;
    result_t     r;
    miso = MISO_IDLE;
    a = ee_addr;
    case (kind)
      KIND_BYTE: begin
        case (ee_phase)
          PH_CMD: begin
            if (ee_busy != 0 && b != BYTE_RDSR) begin
              ee_phase = PH_SKIP;
            end else if (b == BYTE_WREN) begin
              ee_cmd = CMD_WREN;
              ee_wel = 1'b1;
              ee_phase = PH_SKIP;
            end else if (b == BYTE_WRDI) begin
              ee_cmd = CMD_WRDI;
              ee_wel = 1'b0;
              ee_phase = PH_SKIP;
            end else if (b == BYTE_RDSR) begin
              ee_cmd = CMD_RDSR;
              ee_phase = PH_STAT;
            end else if (b == BYTE_READ) begin
              ee_cmd = CMD_READ;
              ee_phase = PH_AHI;
            end else if (b == BYTE_WRITE && ee_wel) begin
              ee_cmd = CMD_WRITE;
              ee_phase = PH_AHI;
            end else if (b == BYTE_WRSR && ee_wel) begin
              ee_cmd = CMD_WRSR;
              ee_phase = PH_WRSR;
            end else begin
              ee_cmd = CMD_NONE;
              ee_phase = PH_SKIP;
            end
          end
          PH_AHI: begin
            // top address bit falls outside the array
            ee_addr = {b[6:0], 8'h00};
            ee_phase = PH_ALO;
          end
          PH_ALO: begin
            ee_addr[7:0] = b;
            ee_phase = PH_DATA;
          end
          PH_DATA: begin
            if (ee_cmd == CMD_READ) begin
              miso = ee_image[a];
              ee_addr = a + 15'd1;
            end else begin
              if (!(ee_bp == 2'd3 || (ee_bp == 2'd2 && a[14]) ||
                    (ee_bp == 2'd1 && a[14:13] == 2'b11)))
                ee_image[a] = b;
              ee_seen = 1'b1;
              // wrap inside the page
              ee_addr = {a[14:6], a[5:0] + 6'd1};
            end
          end
          PH_STAT: miso = {4'b0000, ee_bp, ee_wel, ee_busy != 0};
          PH_WRSR: begin
            ee_bp = b[3:2];
            ee_seen = 1'b1;
            ee_phase = PH_SKIP;
          end
          default: ;
        endcase
      end
      KIND_RELEASE: begin
        if (ee_seen && (ee_cmd == CMD_WRITE || ee_cmd == CMD_WRSR)) begin
          ee_busy = cycle_len;
          ee_wel = 1'b0;
        end
        ee_phase = PH_CMD;
        ee_cmd = CMD_NONE;
        ee_seen = 1'b0;
      end
      KIND_TICK: if (ee_busy != 0) ee_busy = ee_busy - 16'd1;
      default: ;
    endcase
    r.miso = miso;
    r.wip = ee_busy != 0;
    r.wen = ee_wel;
    due_results.push_back(r);
  endtask

  // Driver: hold an item until taken, then load the next one from the queue.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        advance_device(item_kind_t'(opcode), mosi_byte);
        in_flight--;
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (!calm && pending.size() > 0 && $urandom_range(15) == 0) begin
          send_gap = $urandom_range(0, 15);
          push <= 1'b0;
        end else if (pending.size() > 0) begin
          nxt = pending.pop_front();
          in_flight++;
          push <= 1'b1;
          opcode <= nxt.kind;
          mosi_byte <= nxt.data;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each popped result with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          report_error($sformatf("unexpected result miso=%02h wip=%0b wen=%0b",
                                 miso_byte, write_in_progress, write_enabled));
        end else begin
          want = due_results.pop_front();
          if (miso_byte !== want.miso)
            report_error($sformatf("miso_byte %02h, expected %02h", miso_byte, want.miso));
          if (write_in_progress !== want.wip)
            report_error($sformatf("write_in_progress %0b, expected %0b",
                                   write_in_progress, want.wip));
          if (write_enabled !== want.wen)
            report_error($sformatf("write_enabled %0b, expected %0b",
                                   write_enabled, want.wen));
        end
      end
      if (!calm && pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(15) == 0) begin
        pop_gap = $urandom_range(0, 15);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic put(input item_kind_t kind, input logic [7:0] data);
    item_t it;
    it.kind = kind;
    it.data = data;
    pending.push_back(it);
    queued++;
  endtask

  task automatic put_ticks(input int n);
    repeat (n) put(KIND_TICK, 8'($urandom));
  endtask

  // One select-low transaction: command, optional address, n bytes, release.
  task automatic frame(input logic [7:0] op, input bit with_addr, input logic [15:0] a,
                       input int n, input logic [7:0] lead);
    int i;
    put(KIND_BYTE, op);
    if (with_addr) begin
      put(KIND_BYTE, a[15:8]);
      put(KIND_BYTE, a[7:0]);
    end
    for (i = 0; i < n; i++) put(KIND_BYTE, (i == 0) ? lead : 8'($urandom));
    put(KIND_RELEASE, 8'($urandom));
  endtask

  function automatic logic [15:0] pick_addr();
    logic [15:0] r;
    r = 16'($urandom);
    case ($urandom_range(3))
      0: return {r[15:6], 6'd60 + 6'(r[1:0])};
      1: return {r[15], 12'hFFF, r[2:0]};
      default: return r;
    endcase
  endfunction

  task automatic random_frames(input int count);
    int stop;
    int sel;
    int n;
    logic [15:0] a;
    stop = queued + count;
    while (queued < stop) begin
      sel = $urandom_range(99);
      if (sel < 28) begin
        if ($urandom_range(9) != 0) frame(BYTE_WREN, 1'b0, 16'h0, 0, 8'h00);
        a = pick_addr();
        last_write = a;
        n = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 6);
        frame(BYTE_WRITE, 1'b1, a, n, 8'($urandom));
        put_ticks($urandom_range(0, cycle_len + 2));
      end else if (sel < 50) begin
        a = $urandom_range(1) ? last_write : pick_addr();
        n = ($urandom_range(3) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        frame(BYTE_READ, 1'b1, a, n, 8'($urandom));
      end else if (sel < 60) begin
        frame(BYTE_RDSR, 1'b0, 16'h0, $urandom_range(0, 4), 8'($urandom));
      end else if (sel < 70) begin
        if ($urandom_range(4) != 0) frame(BYTE_WREN, 1'b0, 16'h0, 0, 8'h00);
        // clear the protect bits about half the time
        frame(BYTE_WRSR, 1'b0, 16'h0, $urandom_range(0, 2),
              $urandom_range(1) ? 8'($urandom) & 8'hF3 : 8'($urandom));
        put_ticks($urandom_range(0, cycle_len + 2));
      end else if (sel < 76) begin
        frame($urandom_range(1) ? BYTE_WRDI : BYTE_WREN, 1'b0, 16'h0,
              $urandom_range(0, 1), 8'($urandom));
      end else if (sel < 84) begin
        put_ticks($urandom_range(1, cycle_len + 3));
      end else begin
        case ($urandom_range(2))
          0: put(KIND_IDLE, 8'($urandom));
          1: put(KIND_RELEASE, 8'($urandom));
          default: begin
            repeat ($urandom_range(1, 5)) put(KIND_BYTE, 8'($urandom));
            if ($urandom_range(4) != 0) put(KIND_RELEASE, 8'($urandom));
          end
        endcase
      end
    end
  endtask

  task automatic drain();
    while (pending.size() != 0 || in_flight != 0 || due_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_cycle_len(input logic [15:0] v);
    ticks_we <= 1'b1;
    ticks_val <= v;
    @(posedge clk);
    ticks_we <= 1'b0;
    cycle_len = v;
  endtask

  initial begin
    for (int i = 0; i < MEM_SZ; i++) ee_image[i] = ERASED_BYTE;
    ee_phase = PH_CMD;
    ee_cmd = CMD_NONE;
    ee_addr = 15'd0;
    ee_wel = 1'b0;
    ee_bp = 2'd0;
    ee_busy = 16'd0;
    ee_seen = 1'b0;
    cycle_len = TICKS_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_cycle_len(16'd24);

    // directed: status, unknown command, write without latch, idle and tick
    frame(BYTE_RDSR, 1'b0, 16'h0, 1, 8'($urandom));
    frame(8'hA5, 1'b0, 16'h0, 1, BYTE_RDSR);
    frame(BYTE_WRITE, 1'b0, 16'h0, 1, 8'h00);
    put(KIND_IDLE, 8'hFF);
    put(KIND_TICK, 8'h00);
    frame(BYTE_WREN, 1'b0, 16'h0, 0, 8'h00);
    // release before any data: no busy period, latch kept
    frame(BYTE_WRITE, 1'b0, 16'h0, 1, 8'hFF);
    // address beyond memory, then a short busy period
    frame(BYTE_WRITE, 1'b1, 16'hFFFF, 1, 8'h5A);
    frame(BYTE_RDSR, 1'b0, 16'h0, 2, 8'h00);
    frame(BYTE_READ, 1'b0, 16'h0, 1, 8'h00);
    put_ticks(cycle_len);
    // read across the end of memory
    frame(BYTE_READ, 1'b1, 16'hFFFF, 2, 8'h00);
    drain();

    set_cycle_len(16'd0);
    random_frames(280);
    drain();

    set_cycle_len(16'd120);
    frame(BYTE_WREN, 1'b0, 16'h0, 0, 8'h00);
    frame(BYTE_WRSR, 1'b0, 16'h0, 1, 8'h00);
    frame(BYTE_RDSR, 1'b0, 16'h0, 1, 8'h00);
    put_ticks(cycle_len);
    frame(BYTE_RDSR, 1'b0, 16'h0, 1, 8'h00);
    drain();

    set_cycle_len(16'($urandom_range(1, 12)));
    random_frames(160);
    // hold the sender until every response is back
    drain();
    random_frames(160);
    drain();

    set_cycle_len(16'($urandom_range(1, 6)));
    calm = 1'b1;
    random_frames(140);
    drain();
    repeat (8) @(posedge clk);

    if (errors == 0)
      $display("spi_eeprom_device_model_core_tb: clean");
    else
      $display("spi_eeprom_device_model_core_tb: errors");
    $finish;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("spi_eeprom_device_model_core_tb: errors");
    $finish;
  end

endmodule
